// File: hw/rtl/pid_controller_three_variant_unit_defines.svh
// ----------------------------------------------------------------------------
// pid_controller_three_variant_unit_defines
// assertion macros for the pid controller block
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_THREE_VARIANT_UNIT_DEFINES_SVH
`define PID_CONTROLLER_THREE_VARIANT_UNIT_DEFINES_SVH

// property that holds on every clock edge outside reset
`define PID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define PID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// shared types and constants of the pid controller block
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned AccBitsDef    = 48;
  localparam int unsigned GainBits      = 16;
  localparam int unsigned DtBits        = 16;
  localparam int unsigned LimBits       = 32;
  localparam int unsigned CfgIdxBits    = 3;
  localparam int unsigned CfgDataBits   = 32;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegVariant = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegProp    = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegInteg   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegDeriv   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegWindup  = 3'd4;

  // variant codes
  localparam logic [1:0] VarPlain  = 2'd0;
  localparam logic [1:0] VarScaled = 2'd1;
  localparam logic [1:0] VarGuard  = 2'd2;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StProp  = 9'b000000010,
    StInc   = 9'b000000100,
    StInc2  = 9'b000001000,
    StSum   = 9'b000010000,
    StDiv   = 9'b000100000,
    StDeriv = 9'b001000000,
    StInteg = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

endpackage

// File: hw/rtl/pid_controller_three_variant_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_three_variant_unit
// three-variant pid controller built around one shared saturating multiplier
// and a bit-serial signed divider
// ----------------------------------------------------------------------------
// Usage: one input transaction on the s_axis group carries a sample and a
// time step; one output transaction on m_axis carries the saturated drive.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// The block handles one transaction at a time: s_axis_tready is high only in
// the idle state. Every item walks a sequencer that uses one multiply-with-
// saturation unit per step (proportional, integral increment, derivative,
// integral term) and, for variants 1 and 2, a restoring divider that yields
// AccBits quotient bits. Variant 0 steps through the proportional, sum,
// derivative and integral states to the output; variant 1 adds two
// integral-increment states and the divide state, variant 2 adds one of each;
// a new item can be taken the cycle after the result is delivered.
// The result sits in an output register; when the receiver stalls the block
// holds m_axis_tvalid and the data and accepts nothing more.
// Reset clears the configuration, the stored sample, error and error sum,
// and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`include "pid_controller_three_variant_unit_defines.svh"

module pid_controller_three_variant_unit
  import pid_pkg::*;
#(
  parameter int unsigned SampleBits = SampleBitsDef,
  parameter int unsigned AccBits    = AccBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [CfgDataBits-1:0]      cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // sample [SampleBits-1:0], step_time above, zero pad to bytes
  input  logic [((SampleBits+DtBits+7)/8)*8-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // drive [AccBits-1:0], zero pad to bytes
  output logic [((AccBits+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned InW  = ((SampleBits+DtBits+7)/8)*8;
  localparam int unsigned OutW = ((AccBits+7)/8)*8;
  localparam int unsigned MulW = AccBits + GainBits + 1;
  localparam int unsigned CntW = $clog2(AccBits+1);
  localparam logic signed [AccBits-1:0] AccMax = {1'b0, {(AccBits-1){1'b1}}};
  localparam logic signed [AccBits-1:0] AccMin = {1'b1, {(AccBits-1){1'b0}}};

  // configuration registers
  logic [1:0]          variant_q;
  logic [GainBits-1:0] kp_q, ki_q, kd_q;
  logic [LimBits-1:0]  lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VarPlain;
      kp_q <= '0; ki_q <= '0; kd_q <= '0; lim_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegVariant: variant_q <= cfg_data_i[1:0];
        RegProp:    kp_q      <= cfg_data_i[GainBits-1:0];
        RegInteg:   ki_q      <= cfg_data_i[GainBits-1:0];
        RegDeriv:   kd_q      <= cfg_data_i[GainBits-1:0];
        RegWindup:  lim_q     <= cfg_data_i[LimBits-1:0];
        default: ;
      endcase
    end
  end

  // saturating helpers
  function automatic logic signed [AccBits-1:0] sat_add(
      input logic signed [AccBits-1:0] a, input logic signed [AccBits-1:0] b);
    logic signed [AccBits:0] s;
    s = {a[AccBits-1], a} + {b[AccBits-1], b};
    if (s[AccBits] != s[AccBits-1]) return s[AccBits] ? AccMin : AccMax;
    return s[AccBits-1:0];
  endfunction

  state_e state_q, state_d;
  logic [SampleBits-1:0]        last_s_q, s_q;
  logic signed [SampleBits:0]   last_e_q;
  logic signed [AccBits-1:0]    sum_q, e_q, de_q, pterm_q, inc_q, dterm_q, drive_q;
  logic [DtBits-1:0]            dt_q;

  // shared multiplier operands, combinational saturated product
  logic signed [AccBits-1:0]  mul_x;
  logic [GainBits-1:0]        mul_g;
  logic signed [MulW-1:0]     mul_p;
  logic signed [AccBits-1:0]  mul_sat;

  always_comb begin
    mul_x = e_q;
    mul_g = kp_q;
    case (state_q)
      StProp:  begin mul_x = e_q;   mul_g = kp_q; end
      StInc:   begin mul_x = e_q;   mul_g = (variant_q == VarScaled) ? ki_q : dt_q; end
      StInc2:  begin mul_x = inc_q; mul_g = dt_q; end
      StSum:   begin mul_x = de_q;  mul_g = kd_q; end
      StDeriv: begin mul_x = (variant_q == VarGuard) ? dterm_q : de_q; mul_g = kd_q; end
      StInteg: begin mul_x = sum_q; mul_g = ki_q; end
      default: ;
    endcase
    mul_p = mul_x * $signed({1'b0, mul_g});
    if (mul_p > $signed({{(MulW-AccBits){1'b0}}, AccMax}))      mul_sat = AccMax;
    else if (mul_p < $signed({{(MulW-AccBits){1'b1}}, AccMin})) mul_sat = AccMin;
    else mul_sat = mul_p[AccBits-1:0];
  end

  // bit-serial restoring divider on magnitudes
  logic [AccBits-1:0] quo_q, rem_q;
  logic [CntW-1:0]    cnt_q;
  logic               neg_q;
  logic [AccBits:0]   rem_try;
  assign rem_try = {rem_q, quo_q[AccBits-1]} - {{(AccBits+1-DtBits){1'b0}}, dt_q};

  // windup clamp
  logic signed [AccBits-1:0] sum_new, lim_s, sum_cl;
  assign sum_new = sat_add(sum_q, inc_q);
  assign lim_s   = $signed({{(AccBits-LimBits){1'b0}}, lim_q});
  always_comb begin
    sum_cl = sum_new;
    if (variant_q == VarGuard) begin
      if (sum_new < -lim_s)     sum_cl = -lim_s;
      else if (sum_new > lim_s) sum_cl = lim_s;
    end
  end

  logic in_hs, out_hs;
  assign in_hs  = s_axis_tvalid && s_axis_tready;
  assign out_hs = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = OutW'($unsigned(drive_q));

  logic [SampleBits-1:0] in_s;
  logic [DtBits-1:0]     in_dt;
  logic signed [AccBits-1:0] e_new;
  assign in_s  = s_axis_tdata[SampleBits-1:0];
  assign in_dt = s_axis_tdata[SampleBits+DtBits-1:SampleBits];
  assign e_new = AccBits'($signed({1'b0, in_s}) - $signed({1'b0, last_s_q}));

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_hs) state_d = StProp;
      StProp:  state_d = (variant_q == VarScaled || variant_q == VarGuard) ? StInc : StSum;
      StInc:   state_d = (variant_q == VarScaled) ? StInc2 : StSum;
      StInc2:  state_d = StSum;
      StSum:   state_d = (variant_q == VarScaled || variant_q == VarGuard) ? StDiv
                                                                             : StDeriv;
      StDiv:   if (cnt_q == CntW'(1)) state_d = StDeriv;
      StDeriv: state_d = StInteg;
      StInteg: state_d = StOut;
      StOut:   if (out_hs) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      last_s_q <= '0;
      last_e_q <= '0;
      sum_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: if (in_hs) begin
          last_s_q <= in_s;
          last_e_q <= e_new[SampleBits:0];
        end
        StSum: sum_q <= sum_cl;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (in_hs) begin
        e_q   <= e_new;
        de_q  <= e_new - AccBits'(last_e_q);
        dt_q  <= (in_dt == '0) ? DtBits'(1) : in_dt;
        inc_q <= e_new;
      end
      StProp: pterm_q <= mul_sat;
      StInc:  inc_q   <= mul_sat;
      StInc2: inc_q   <= mul_sat;
      StSum: begin
        // divide kd*de (scaled) or de (guard) by dt
        if (variant_q == VarScaled) dterm_q <= mul_sat;
        neg_q <= (variant_q == VarScaled) ? mul_sat[AccBits-1] : de_q[AccBits-1];
        quo_q <= (variant_q == VarScaled)
                 ? (mul_sat[AccBits-1] ? -mul_sat : mul_sat)
                 : (de_q[AccBits-1] ? -de_q : de_q);
        rem_q <= '0;
        cnt_q <= CntW'(AccBits);
      end
      StDiv: begin
        cnt_q <= cnt_q - CntW'(1);
        if (!rem_try[AccBits]) begin
          rem_q <= rem_try[AccBits-1:0];
          quo_q <= {quo_q[AccBits-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[AccBits-2:0], quo_q[AccBits-1]};
          quo_q <= {quo_q[AccBits-2:0], 1'b0};
        end
        if (cnt_q == CntW'(1)) begin
          dterm_q <= (!rem_try[AccBits])
                     ? (neg_q ? -$signed({quo_q[AccBits-2:0], 1'b1})
                              : $signed({quo_q[AccBits-2:0], 1'b1}))
                     : (neg_q ? -$signed({quo_q[AccBits-2:0], 1'b0})
                              : $signed({quo_q[AccBits-2:0], 1'b0}));
        end
      end
      StDeriv: begin
        if (variant_q == VarScaled) dterm_q <= dterm_q;
        else dterm_q <= mul_sat;
      end
      StInteg: begin
        if (variant_q == VarScaled) drive_q <= sat_add(sat_add(pterm_q, sum_q), dterm_q);
        else drive_q <= sat_add(sat_add(pterm_q, mul_sat), dterm_q);
      end
      default: ;
    endcase
  end

  // checks
  `PID_ASSERT(a_ready_idle, s_axis_tready == (state_q == StIdle), "ready outside idle")
  `PID_ASSERT(a_not_both, !(s_axis_tready && m_axis_tvalid), "ready while output pending")
  `PID_ASSERT_NEXT(a_hold_out, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(drive_q), "output dropped on stall")
  `PID_ASSERT_NEXT(a_accept_starts, in_hs, state_q == StProp, "accept did not start work")

endmodule
